/* rtl/dbl_pkg.sv */
// shared types and constants for the directive block locator
package dbl_pkg;

  localparam int unsigned DIR_LEN = 8;
  localparam logic [3:0] DIR_LEN_C = 4'd8;
  localparam logic [7:0] AT_CHAR = 8'h40;
  localparam logic [7:0] NL_CHAR = 8'h0A;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_SKIP   = 2'd1,
    PH_BODY   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef struct packed {
    logic        emit;
    logic        found;
    logic [31:0] block_offset;
    logic [31:0] block_length;
  } dbl_res_t;

  // directive text, one character per index
  function automatic logic [7:0] dir_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h40; // '@'
      3'd1: c = 8'h57; // 'W'
      3'd2: c = 8'h45; // 'E'
      3'd3: c = 8'h42; // 'B'
      3'd4: c = 8'h44; // 'D'
      3'd5: c = 8'h49; // 'I'
      3'd6: c = 8'h43; // 'C'
      3'd7: c = 8'h54; // 'T'
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/dbl_if.sv */
// valid/ready channel interfaces for input bytes and located blocks
interface dbl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface dbl_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] block_offset;
  logic [31:0] block_length;

  modport source (output valid, output found, output block_offset, output block_length,
                  input ready);
  modport sink (input valid, input found, input block_offset, input block_length,
                output ready);
endinterface

/* rtl/dbl_step.sv */
// scan state and the per-byte update and result logic
module dbl_step #(
  parameter int unsigned POS_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [7:0]      data_byte,
  input  logic            is_last,
  output dbl_pkg::dbl_res_t res
);
  import dbl_pkg::*;

  localparam int unsigned EXT_BITS = (POS_BITS > 32) ? POS_BITS : 32;

  phase_t              phase, phase_next, phase_mid;
  logic                line_start, line_start_next;
  logic [3:0]          match_count, match_count_next, mc_tmp;
  logic [POS_BITS-1:0] byte_position, byte_position_next, pos_inc;
  logic [POS_BITS-1:0] body_start, body_start_next, body_mid;
  logic                close;
  logic [POS_BITS-1:0] len_base, len;
  logic                in_body;

  function automatic logic [31:0] clamp_out(input logic [POS_BITS-1:0] v);
    logic [EXT_BITS-1:0] ext;
    ext = EXT_BITS'(v);
    if (ext > EXT_BITS'(33'h0_FFFF_FFFF)) return 32'hFFFF_FFFF;
    return ext[31:0];
  endfunction

  assign pos_inc = (byte_position == {POS_BITS{1'b1}}) ? byte_position
                                                        : byte_position + 1'b1;

  // next state
  always_comb begin
    phase_mid = phase;
    line_start_next = line_start;
    match_count_next = match_count;
    body_mid = body_start;
    close = 1'b0;
    mc_tmp = 4'd0;
    case (phase)
      PH_SKIP: begin
        if (data_byte == NL_CHAR) begin
          phase_mid = PH_BODY;
          body_mid = pos_inc;
          line_start_next = 1'b1;
        end
      end
      PH_BODY: begin
        if (line_start && data_byte == AT_CHAR) begin
          close = 1'b1;
          phase_mid = PH_DONE;
        end else begin
          line_start_next = (data_byte == NL_CHAR);
        end
      end
      PH_DONE: begin
      end
      default: begin
        if (line_start && data_byte == AT_CHAR) begin
          mc_tmp = 4'd1;
        end else if (match_count != 4'd0 && match_count < DIR_LEN_C &&
                     data_byte == dir_char(match_count[2:0])) begin
          mc_tmp = 4'(match_count + 4'd1);
        end else begin
          mc_tmp = 4'd0;
        end
        if (mc_tmp == DIR_LEN_C) begin
          phase_mid = PH_SKIP;
          match_count_next = 4'd0;
        end else begin
          match_count_next = mc_tmp;
          line_start_next = (data_byte == NL_CHAR);
        end
      end
    endcase
    phase_next = phase_mid;
    body_start_next = body_mid;
    byte_position_next = pos_inc;
    // last byte of the file starts a fresh scan
    if (is_last) begin
      phase_next = PH_SEARCH;
      line_start_next = 1'b1;
      match_count_next = 4'd0;
      byte_position_next = '0;
      body_start_next = '0;
    end
  end

  // result
  always_comb begin
    in_body = close || (phase_mid == PH_BODY);
    len_base = close ? byte_position : pos_inc;
    len = (len_base > body_mid) ? len_base - body_mid : '0;
    res.emit = close || (is_last && phase_mid != PH_DONE);
    res.found = in_body && (len != '0);
    res.block_offset = res.found ? clamp_out(body_mid) : 32'd0;
    res.block_length = res.found ? clamp_out(len) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
      line_start <= 1'b1;
      match_count <= 4'd0;
      byte_position <= '0;
      body_start <= '0;
    end else if (fire) begin
      phase <= phase_next;
      line_start <= line_start_next;
      match_count <= match_count_next;
      byte_position <= byte_position_next;
      body_start <= body_start_next;
    end
  end

endmodule

/* rtl/directive_block_locator.sv */
// top level: input word register, scan logic and result register
//
//  channel  | dir | payload                              | word
//  ---------+-----+--------------------------------------+-----------------------------
//  in_ch    | in  | data_byte[7:0], is_last              | one byte of the file
//  out_ch   | out | found, block_offset[31:0], block_length[31:0] | one located block
//
//  one byte is taken every cycle while out_ch is not stalled; its result passes through the
//  input register and then the result register before it is on out_ch
//  the scan state is updated from the input register
//  rst (synchronous) empties both registers and restarts the scan at file offset zero
//  a stalled result holds the output register; the input register then fills and
//  ready drops until the result is taken
module directive_block_locator #(
  parameter int unsigned POS_BITS = 32
) (
  input logic     clk,
  input logic     rst,
  dbl_in_if.sink  in_ch,
  dbl_out_if.source out_ch
);
  import dbl_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // result register
  logic        out_valid;
  logic        out_found;
  logic [31:0] out_offset;
  logic [31:0] out_length;

  logic     advance;
  logic     fire;
  dbl_res_t res;

  // the scan may move on whenever the result register is free or being emptied
  assign advance = !out_valid || out_ch.ready;
  assign fire = in_valid_q && advance;
  assign in_ch.ready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_q <= in_ch.data_byte;
      in_last_q <= in_ch.is_last;
    end
  end

  dbl_step #(
    .POS_BITS(POS_BITS)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (in_byte_q),
    .is_last   (in_last_q),
    .res       (res)
  );

  // at most one result per byte; held until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.emit) begin
      out_found <= res.found;
      out_offset <= res.block_offset;
      out_length <= res.block_length;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.found = out_found;
  assign out_ch.block_offset = out_offset;
  assign out_ch.block_length = out_length;

endmodule

/* rtl/dbl_checker.sv */
// port-level checks for the directive block locator, bound to the top level
module dbl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic [31:0] block_offset,
  input logic [31:0] block_length
);

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a waiting result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(found) && $stable(block_offset) &&
    $stable(block_length))
    else $error("result changed while stalled");

  // a miss carries zero offset and length
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> block_offset == 32'd0 && block_length == 32'd0)
    else $error("miss with non-zero fields");

  // a hit always has a body
  a_hit_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> block_length != 32'd0)
    else $error("hit with empty body");

  // with the sink ready the input never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled with sink ready");

endmodule

bind directive_block_locator dbl_checker u_dbl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .found        (out_ch.found),
  .block_offset (out_ch.block_offset),
  .block_length (out_ch.block_length)
);
